### design/bilinear_warp_frame_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear warp frame engine
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_WARP_FRAME_ENGINE_MACROS_SVH
`define BILINEAR_WARP_FRAME_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Checked property with reset masking.
`define BWFE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked property that also holds during reset.
`define BWFE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BWFE_ASSERT(name, clk, rst, prop)
`define BWFE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### design/bwfe_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear warp frame engine package
// Shared types and constants for the front, queue and back modules.
// ----------------------------------------------------------------------------
package bwfe_pkg;

  // Width of a computed linear address before it is fitted to the store.
  localparam int ADDR_W = 22;
  localparam int SIZE_W = 20;
  localparam int QUEUE_DEPTH = 2;

  // Input item kinds.
  localparam logic [1:0] KIND_PLOT = 2'd0;
  localparam logic [1:0] KIND_WARP = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_PLOT,
    OP_WARP,
    OP_READ
  } op_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   base;
    logic [3:0]          mask;
    logic [7:0]          value;
    logic [3:0][7:0]     weight;
    logic                oob;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WARP,
    S_WFIN,
    S_WOUT,
    S_PRD,
    S_PWR,
    S_RRD,
    S_ROUT
  } state_t;

endpackage

### design/bilinear_warp_frame_engine.sv
// ----------------------------------------------------------------------------
// Bilinear warp frame engine
// Double-buffered 8-bit frame stores with max-plot, bilinear warp and read.
// ----------------------------------------------------------------------------
// After reset the engine clears both frame stores, one address a cycle, over
// all MAX_WIDTH*MAX_HEIGHT addresses before it takes the first queued item. Items
// are executed one at a time against a single-ported read of the front store:
// a warp makes four neighbor reads, an accumulate and a write-back, a read
// makes one read, and a plot makes a read and a max-write for one pixel or for
// each pixel of a 2x2 square. A two-entry queue lets the input keep accepting
// while an item executes, and the result register lets the next item start
// while a result waits on the output.
module bilinear_warp_frame_engine #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_pos[10:0], y_pos[21:11], plot_value[29:22], plot_square[30],
  // weight_top_left[38:31], weight_right[46:39], weight_below[54:47],
  // weight_below_right[62:55], zero fill[63]
  input  logic [63:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel[7:0], pixel_index[25:8], zero fill[31:26]
  output logic [31:0] m_tdata,
  // frame_done
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [9:0]                  frame_width, frame_height, w_eff, h_eff;
  logic [bwfe_pkg::SIZE_W-1:0] size;
  logic                        push, full, pop, not_empty;
  bwfe_pkg::entry_t            push_entry, head;

  // Configuration registers.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {22'b0, frame_height} : {22'b0, frame_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 10'd256;
      frame_height <= 10'd256;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) frame_height <= pwdata[9:0];
      else frame_width <= pwdata[9:0];
    end
  end

  // Effective frame size, clamped to the supported range.
  always_comb begin
    w_eff = frame_width;
    if (frame_width < 10'd4) w_eff = 10'd4;
    else if (int'(frame_width) > MAX_WIDTH) w_eff = 10'(MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height < 10'd4) h_eff = 10'd4;
    else if (int'(frame_height) > MAX_HEIGHT) h_eff = 10'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    size <= w_eff * h_eff;
  end

  bwfe_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .w(w_eff), .h(h_eff), .size(size), .full(full),
    .push(push), .push_entry(push_entry)
  );

  bwfe_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .full(full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  bwfe_back #(.DEPTH(DEPTH)) u_back (
    .clk(clk), .rst(rst), .w(w_eff), .size(size),
    .not_empty(not_empty), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

### design/bwfe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bwfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bwfe_queue.sv
// ----------------------------------------------------------------------------
// Item queue
// Short FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module bwfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bwfe_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output bwfe_pkg::entry_t head
);

  bwfe_pkg::entry_t entries [bwfe_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(bwfe_pkg::QUEUE_DEPTH));
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/bwfe_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input items, computes addresses and term masks, queues the work.
// ----------------------------------------------------------------------------
module bwfe_front (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // x_pos[10:0], y_pos[21:11], plot_value[29:22], plot_square[30],
  // weight_top_left[38:31], weight_right[46:39], weight_below[54:47],
  // weight_below_right[62:55]
  input  logic [63:0]                 s_tdata,
  // kind[1:0]
  input  logic [1:0]                  s_tuser,
  input  logic [9:0]                  w,
  input  logic [9:0]                  h,
  input  logic [bwfe_pkg::SIZE_W-1:0] size,
  input  logic                        full,
  output logic                        push,
  output bwfe_pkg::entry_t            push_entry
);

  logic signed [11:0]          xs, ys, wlim, hlim;
  logic [10:0]                 x_pos, y_pos;
  logic [19:0]                 prod;
  logic [bwfe_pkg::ADDR_W-1:0] base, b1, bw, bw1, sz;
  logic                        neg, plot_ok, keep;

  assign x_pos = s_tdata[10:0];
  assign y_pos = s_tdata[21:11];

  // Plot window test in signed arithmetic.
  assign xs      = {x_pos[10], x_pos};
  assign ys      = {y_pos[10], y_pos};
  assign wlim    = $signed({2'b00, w}) - 12'sd3;
  assign hlim    = $signed({2'b00, h}) - 12'sd3;
  assign plot_ok = (xs > 12'sd0) && (xs < wlim) && (ys > 12'sd0) && (ys < hlim);
  assign neg     = x_pos[10] | y_pos[10];

  // Linear address of the item and of its three neighbors.
  assign prod = y_pos[9:0] * w;
  assign base = bwfe_pkg::ADDR_W'(prod) + bwfe_pkg::ADDR_W'(x_pos[9:0]);
  assign b1   = base + 22'd1;
  assign bw   = base + bwfe_pkg::ADDR_W'(w);
  assign bw1  = bw + 22'd1;
  assign sz   = bwfe_pkg::ADDR_W'(size);

  // Classify the item; ignored items are consumed without queuing.
  always_comb begin
    push_entry.base   = base;
    push_entry.value  = s_tdata[29:22];
    push_entry.weight = {s_tdata[62:55], s_tdata[54:47], s_tdata[46:39], s_tdata[38:31]};
    push_entry.oob    = neg || (x_pos[9:0] >= w) || (y_pos[9:0] >= h);
    push_entry.op     = bwfe_pkg::OP_READ;
    push_entry.mask   = 4'b0000;
    keep              = 1'b0;
    unique case (s_tuser)
      bwfe_pkg::KIND_PLOT: begin
        push_entry.op   = bwfe_pkg::OP_PLOT;
        push_entry.mask = s_tdata[30] ? 4'b1111 : 4'b0001;
        keep            = plot_ok;
      end
      bwfe_pkg::KIND_WARP: begin
        push_entry.op   = bwfe_pkg::OP_WARP;
        push_entry.mask = {!neg && (bw1 < sz), !neg && (bw < sz),
                           !neg && (b1 < sz), !neg && (base < sz)};
        keep            = 1'b1;
      end
      bwfe_pkg::KIND_READ: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready && keep;

endmodule

### design/bwfe_back.sv
// ----------------------------------------------------------------------------
// Back end
// Sequences frame store accesses for plot, warp and read, and owns the
// frame swap, the destination index and the result register.
// ----------------------------------------------------------------------------
`include "bilinear_warp_frame_engine_macros.svh"

module bwfe_back #(
  parameter int DEPTH = 262144
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [9:0]                  w,
  input  logic [bwfe_pkg::SIZE_W-1:0] size,
  input  logic                        not_empty,
  input  bwfe_pkg::entry_t            head,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // pixel[7:0], pixel_index[25:8], zero fill[31:26]
  output logic [31:0]                 m_tdata,
  output logic                        m_tlast
);

  localparam int AW = $clog2(DEPTH);

  bwfe_pkg::state_t state, state_next;
  bwfe_pkg::entry_t cur;
  logic [1:0]                  cnt, cnt_next, rd_term;
  logic [17:0]                 acc;
  logic                        rd_pend, rd_pend_next;
  logic                        front_is_b;
  logic [bwfe_pkg::SIZE_W-1:0] dest, dest_use;
  logic [bwfe_pkg::SIZE_W:0]   dest_inc;
  logic [AW-1:0]               clr_addr;
  logic                        out_valid, out_done;
  logic [7:0]                  out_pixel;
  logic [17:0]                 out_index;

  logic                        rd_en, wr_front, wr_back, clr_we, out_load, out_free;
  logic                        out_done_next, warp_commit;
  logic [7:0]                  out_pixel_next, wr_data, rdata_a, rdata_b, rdata_front;
  logic [17:0]                 out_index_next;
  logic [bwfe_pkg::ADDR_W-1:0] term_addr, wr_addr;
  logic                        we_a, we_b;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [7:0]                  ram_wdata;
  logic [15:0]                 prod;

  // Address of the current term: base, right, below, below right.
  assign term_addr = cur.base + (cnt[1] ? bwfe_pkg::ADDR_W'(w) : '0)
                   + bwfe_pkg::ADDR_W'(cnt[0]);
  assign rdata_front = front_is_b ? rdata_b : rdata_a;
  assign out_free    = !out_valid || m_tready;
  assign dest_use    = (dest >= size) ? '0 : dest;
  assign dest_inc    = {1'b0, dest_use} + 21'd1;
  assign prod        = rdata_front * cur.weight[rd_term];

  // Sequencer: next state and access controls.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_pend_next   = 1'b0;
    wr_front       = 1'b0;
    wr_back        = 1'b0;
    clr_we         = 1'b0;
    wr_addr        = term_addr;
    wr_data        = (rdata_front > cur.value) ? rdata_front : cur.value;
    out_load       = 1'b0;
    out_pixel_next = acc[15:8];
    out_index_next = dest_use[17:0];
    out_done_next  = 1'b0;
    warp_commit    = 1'b0;
    unique case (state)
      bwfe_pkg::S_CLEAR: begin
        clr_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) state_next = bwfe_pkg::S_IDLE;
      end
      bwfe_pkg::S_IDLE: begin
        cnt_next = 2'd0;
        if (not_empty) begin
          pop = 1'b1;
          unique case (head.op)
            bwfe_pkg::OP_PLOT: state_next = bwfe_pkg::S_PRD;
            bwfe_pkg::OP_WARP: state_next = bwfe_pkg::S_WARP;
            default:           state_next = bwfe_pkg::S_RRD;
          endcase
        end
      end
      bwfe_pkg::S_WARP: begin
        rd_en        = 1'b1;
        rd_pend_next = 1'b1;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) state_next = bwfe_pkg::S_WFIN;
      end
      bwfe_pkg::S_WFIN: begin
        state_next = bwfe_pkg::S_WOUT;
      end
      bwfe_pkg::S_WOUT: begin
        wr_addr       = bwfe_pkg::ADDR_W'(dest_use);
        wr_data       = acc[15:8];
        out_done_next = (dest_inc >= {1'b0, size});
        if (out_free) begin
          wr_back     = 1'b1;
          out_load    = 1'b1;
          warp_commit = 1'b1;
          state_next  = bwfe_pkg::S_IDLE;
        end
      end
      bwfe_pkg::S_PRD: begin
        rd_en      = 1'b1;
        state_next = bwfe_pkg::S_PWR;
      end
      bwfe_pkg::S_PWR: begin
        wr_front = 1'b1;
        if (!cur.mask[3] || cnt == 2'd3) begin
          state_next = bwfe_pkg::S_IDLE;
        end else begin
          cnt_next   = cnt + 2'd1;
          state_next = bwfe_pkg::S_PRD;
        end
      end
      bwfe_pkg::S_RRD: begin
        rd_en      = !cur.oob;
        state_next = bwfe_pkg::S_ROUT;
      end
      bwfe_pkg::S_ROUT: begin
        out_pixel_next = cur.oob ? 8'd0 : rdata_front;
        out_index_next = cur.oob ? 18'd0 : cur.base[17:0];
        if (out_free) begin
          out_load   = 1'b1;
          state_next = bwfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bwfe_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bwfe_pkg::S_CLEAR;
      clr_addr   <= '0;
      cnt        <= 2'd0;
      rd_pend    <= 1'b0;
      front_is_b <= 1'b0;
      dest       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
      if (clr_we) clr_addr <= clr_addr + AW'(1);
      if (warp_commit) begin
        if (out_done_next) begin
          dest       <= '0;
          front_is_b <= ~front_is_b;
        end else begin
          dest <= dest_inc[bwfe_pkg::SIZE_W-1:0];
        end
      end
      if (out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  // Datapath registers: current item, accumulator and result.
  always_ff @(posedge clk) begin
    rd_term <= cnt;
    if (pop) cur <= head;
    if (pop) begin
      acc <= '0;
    end else if (rd_pend && cur.mask[rd_term]) begin
      acc <= acc + 18'(prod);
    end
    if (out_load) begin
      out_pixel <= out_pixel_next;
      out_index <= out_index_next;
      out_done  <= out_done_next;
    end
  end

  // Frame store ports: reads go to the front store, plots to the front,
  // warps to the back, and the clearing pass to both.
  assign we_a      = clr_we | (wr_front & ~front_is_b) | (wr_back & front_is_b);
  assign we_b      = clr_we | (wr_front & front_is_b) | (wr_back & ~front_is_b);
  assign ram_waddr = clr_we ? clr_addr : AW'(wr_addr);
  assign ram_wdata = clr_we ? 8'd0 : wr_data;
  assign ram_raddr = AW'(term_addr);

  bwfe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store_a (
    .clk(clk), .we(we_a), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(rd_en), .raddr(ram_raddr), .rdata(rdata_a)
  );

  bwfe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store_b (
    .clk(clk), .we(we_b), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(rd_en), .raddr(ram_raddr), .rdata(rdata_b)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_index, out_pixel};
  assign m_tlast  = out_done;

  // No item is taken while the stores are being cleared.
  `BWFE_ASSERT(a_clear_no_pop, clk, rst, (state == bwfe_pkg::S_CLEAR) |-> !pop)
  // A frame-ending warp swaps the stores.
  `BWFE_ASSERT(a_swap_on_done, clk, rst, (warp_commit && out_done_next) |=> (front_is_b != $past(front_is_b)))
  // Plot and warp never write in the same cycle.
  `BWFE_ASSERT_ALWAYS(a_write_excl, clk, !(wr_front && wr_back))

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Bilinear warp frame engine testbench
// Drives plot, warp and read transactions into the stream port, programs the
// frame size through the APB port, and checks every result against a
// predictor that keeps its own copy of both frame stores.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;
  localparam int STORE_WORDS = 512 * 512;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [7:0]  pixel;
    logic [17:0] index;
    logic        done;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: both frame stores, roles, running index and registers.
  logic [7:0]    store_a [STORE_WORDS];
  logic [7:0]    store_b [STORE_WORDS];
  bit            front_b;
  int            dest_index;
  logic [9:0]    width_reg;
  logic [9:0]    height_reg;
  pixel_result_t expected_pixels[$];
  int            error_count = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;

  bilinear_warp_frame_engine dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_side(logic [9:0] v);
    if (v < 4) return 4;
    if (v > 512) return 512;
    return v;
  endfunction

  function automatic logic [7:0] front_px(int a);
    return front_b ? store_b[a] : store_a[a];
  endfunction

  function automatic void merge_front(int a, logic [7:0] v);
    if (front_px(a) < v) begin
      if (front_b) store_b[a] = v;
      else store_a[a] = v;
    end
  endfunction

  // Update the frame model with one accepted item and queue its result.
  function automatic void predict_frame(logic [1:0] kind, logic [63:0] data);
    int x, y, w, h, size, base, sum, a;
    logic [7:0] wt [4];
    pixel_result_t r;
    x = $signed(data[10:0]);
    y = $signed(data[21:11]);
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    size = w * h;
    for (int i = 0; i < 4; i++) wt[i] = data[31 + 8*i +: 8];
    case (kind)
      bwfe_pkg::KIND_PLOT: begin
        if (x > 0 && x < w - 3 && y > 0 && y < h - 3) begin
          a = y * w + x;
          merge_front(a, data[29:22]);
          if (data[30]) begin
            merge_front(a + 1, data[29:22]);
            merge_front(a + w, data[29:22]);
            merge_front(a + w + 1, data[29:22]);
          end
        end
      end
      bwfe_pkg::KIND_WARP: begin
        sum = 0;
        if (x >= 0 && y >= 0) begin
          base = y * w + x;
          if (base < size) sum += front_px(base) * wt[0];
          if (base + 1 < size) sum += front_px(base + 1) * wt[1];
          if (base + w < size) sum += front_px(base + w) * wt[2];
          if (base + w + 1 < size) sum += front_px(base + w + 1) * wt[3];
        end
        r.pixel = sum >> 8;
        if (dest_index >= size) dest_index = 0;
        r.index = dest_index;
        if (front_b) store_a[dest_index] = r.pixel;
        else store_b[dest_index] = r.pixel;
        dest_index++;
        r.done = 1'b0;
        if (dest_index >= size) begin
          dest_index = 0;
          front_b = !front_b;
          r.done = 1'b1;
        end
        expected_pixels.push_back(r);
      end
      bwfe_pkg::KIND_READ: begin
        r = '{8'd0, 18'd0, 1'b0};
        if (x >= 0 && y >= 0 && x < w && y < h) begin
          a = y * w + x;
          r.pixel = front_px(a);
          r.index = a;
        end
        expected_pixels.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Compare each output transaction with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result pixel=%0d index=%0d", m_tdata[7:0], m_tdata[25:8]);
        error_count++;
      end else begin
        e = expected_pixels.pop_front();
        if (m_tdata[7:0] !== e.pixel) begin
          $error("pixel expected %0d actual %0d", e.pixel, m_tdata[7:0]);
          error_count++;
        end
        if (m_tdata[25:8] !== e.index) begin
          $error("pixel_index expected %0d actual %0d", e.index, m_tdata[25:8]);
          error_count++;
        end
        if (m_tlast !== e.done) begin
          $error("frame_done expected %0d actual %0d", e.done, m_tlast);
          error_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one item; returns at the edge where it is accepted, valid still high.
  task automatic send_item(logic [1:0] kind, int x, int y, logic [7:0] value,
                           logic square, logic [31:0] weights);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < gap_pct && gaps < 20) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {1'b0, weights, square, value, y[10:0], x[10:0]};
    do @(posedge clk); while (!s_tready);
    predict_frame(kind, {1'b0, weights, square, value, y[10:0], x[10:0]});
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!write && prdata[9:0] !== data[9:0]) begin
      $error("register %0d expected %0d actual %0d", addr, data[9:0], prdata[9:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(logic [9:0] w, logic [9:0] h);
    wait_drained();
    apb_access(1'b1, ADDR_WIDTH, w);
    apb_access(1'b1, ADDR_HEIGHT, h);
    apb_access(1'b0, ADDR_WIDTH, w);
    apb_access(1'b0, ADDR_HEIGHT, h);
    width_reg = w;
    height_reg = h;
  endtask

  task automatic test_reset_state();
    front_b = 0;
    dest_index = 0;
    width_reg = 256;
    height_reg = 256;
    for (int i = 0; i < STORE_WORDS; i++) begin
      store_a[i] = 8'd0;
      store_b[i] = 8'd0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, ADDR_WIDTH, 32'd256);
    apb_access(1'b0, ADDR_HEIGHT, 32'd256);
  endtask

  // Field extremes, every kind and the special cases of the frame logic.
  task automatic test_directed();
    set_frame_size(10'd512, 10'd512);
    send_item(bwfe_pkg::KIND_PLOT, 508, 508, 8'hFF, 1'b1, '0);
    send_item(bwfe_pkg::KIND_PLOT, 509, 1, 8'h80, 1'b0, '0);
    send_item(bwfe_pkg::KIND_PLOT, 1, 1, 8'h01, 1'b1, '0);
    send_item(bwfe_pkg::KIND_READ, 509, 509, 8'h00, 1'b0, '0);
    send_item(bwfe_pkg::KIND_READ, 511, 511, 8'h00, 1'b0, '0);
    send_item(bwfe_pkg::KIND_READ, -1, 0, 8'h00, 1'b0, '0);
    send_item(bwfe_pkg::KIND_WARP, 508, 508, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(bwfe_pkg::KIND_WARP, 511, 511, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(bwfe_pkg::KIND_WARP, -1024, 1023, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(bwfe_pkg::KIND_WARP, 1023, 1023, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(KIND_NONE, 5, 5, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    wait_drained();
    // Clamped sizes and a running index that must restart after shrinking.
    set_frame_size(10'd1023, 10'd0);
    send_item(bwfe_pkg::KIND_READ, 511, 3, 8'h00, 1'b0, '0);
    send_item(bwfe_pkg::KIND_PLOT, 508, 0, 8'h55, 1'b1, '0);
    set_frame_size(10'd0, 10'd3);
    for (int i = 0; i < 17; i++)
      send_item(bwfe_pkg::KIND_WARP, i % 5, i / 5, 8'h00, 1'b0, $urandom);
    send_item(bwfe_pkg::KIND_READ, 3, 3, 8'h00, 1'b0, '0);
    send_item(bwfe_pkg::KIND_READ, 4, 0, 8'h00, 1'b0, '0);
  endtask

  // Mostly well-formed traffic on small frames so that frames swap often.
  task automatic test_random_phase(int items, int gaps, int stalls);
    int w, h, pick;
    gap_pct = gaps;
    stall_pct = stalls;
    set_frame_size($urandom_range(12, 4), $urandom_range(12, 4));
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 30)
        send_item(bwfe_pkg::KIND_PLOT, $urandom_range(w - 4, 0), $urandom_range(h - 4, 0),
                  $urandom, $urandom, $urandom);
      else if (pick < 65)
        send_item(bwfe_pkg::KIND_WARP, $urandom_range(w, 0), $urandom_range(h, 0),
                  $urandom, $urandom, $urandom);
      else if (pick < 85)
        send_item(bwfe_pkg::KIND_READ, $urandom_range(w, 0), $urandom_range(h, 0),
                  $urandom, $urandom, $urandom);
      else
        send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    test_reset_state();
    test_directed();
    test_random_phase(200, 0, 0);
    test_random_phase(200, 50, 0);
    test_random_phase(200, 0, 50);
    test_random_phase(200, 6, 6);
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
